FILE: sv/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/snoise_pkg.sv
// package for the 3d simplex noise block: widths, constants, gradient and hash functions
// no dependencies
`default_nettype none

package snoise_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned WorkBits  = 28;
  localparam logic [63:0] FalloffQ28 = 64'd161061274;
  localparam int unsigned OutW      = 18;
  localparam logic [31:0] Recip3    = 32'hAAAAAAAB;

  // gradient components as 2-bit signed codes, indexed by hash bits 3..0
  typedef struct packed {
    logic signed [1:0] gx;
    logic signed [1:0] gy;
    logic signed [1:0] gz;
  } grad_t;

  function automatic grad_t grad_lookup(input logic [3:0] h);
    grad_t g;
    unique case (h)
      4'd0:  g = '{2'sd1,  2'sd1,  2'sd0};
      4'd1:  g = '{-2'sd1, 2'sd1,  2'sd0};
      4'd2:  g = '{2'sd1,  -2'sd1, 2'sd0};
      4'd3:  g = '{-2'sd1, -2'sd1, 2'sd0};
      4'd4:  g = '{2'sd1,  2'sd0,  2'sd1};
      4'd5:  g = '{-2'sd1, 2'sd0,  2'sd1};
      4'd6:  g = '{2'sd1,  2'sd0,  -2'sd1};
      4'd7:  g = '{-2'sd1, 2'sd0,  -2'sd1};
      4'd8:  g = '{2'sd0,  2'sd1,  2'sd1};
      4'd9:  g = '{2'sd0,  -2'sd1, 2'sd1};
      4'd10: g = '{2'sd0,  2'sd1,  -2'sd1};
      4'd11: g = '{2'sd0,  -2'sd1, -2'sd1};
      4'd12: g = '{2'sd1,  2'sd1,  2'sd0};
      4'd13: g = '{2'sd0,  -2'sd1, 2'sd1};
      4'd14: g = '{-2'sd1, 2'sd1,  2'sd0};
      default: g = '{2'sd0, -2'sd1, -2'sd1};
    endcase
    return g;
  endfunction

  // one step of the multiply-xorshift hash
  function automatic logic [31:0] xs(input logic [31:0] h, input int unsigned s);
    return h ^ (h >> s);
  endfunction

  // floor division by three of a 33-bit signed value
  // reciprocal multiply on the magnitude, negatives folded through -1-v
  function automatic logic signed [33:0] floor_div3(input logic signed [32:0] v);
    logic [31:0] u;
    logic [63:0] p;
    logic [30:0] q;
    u = v[32] ? ~v[31:0] : v[31:0];
    p = 64'(u) * 64'(Recip3);
    q = p[63:33];
    return v[32] ? ~{3'b000, q} : {3'b000, q};
  endfunction

endpackage

`default_nettype wire

FILE: sv/snoise_corner.sv
// one simplex corner: hash, falloff and gradient dot, pipelined over several stages
// depends on snoise_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module snoise_corner #(
  parameter int unsigned FRAC_BITS = snoise_pkg::FracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic [31:0]        seed_i,
  // offsets in units of 1/(6*2^FRAC_BITS), corner cell indices
  input  wire logic signed [39:0] ex_i,
  input  wire logic signed [39:0] ey_i,
  input  wire logic signed [39:0] ez_i,
  input  wire logic [31:0]        cx_i,
  input  wire logic [31:0]        cy_i,
  input  wire logic [31:0]        cz_i,
  output logic signed [63:0]      term_o
);

  localparam int unsigned Sh = snoise_pkg::WorkBits - FRAC_BITS;

  // stage 1: offsets to q28 (floor of v*2^(Sh-1)/3, offsets stay below one cell),
  // first hash mix
  logic signed [35:0] qx_d, qy_d, qz_d, qx_q, qy_q, qz_q;
  logic [31:0] h1_d, h1_q, cy1_q, cz1_q;
  always_comb begin
    logic signed [63:0] sx, sy, sz;
    sx = 64'(ex_i) <<< (Sh - 1);
    sy = 64'(ey_i) <<< (Sh - 1);
    sz = 64'(ez_i) <<< (Sh - 1);
    qx_d = 36'(snoise_pkg::floor_div3(sx[32:0]));
    qy_d = 36'(snoise_pkg::floor_div3(sy[32:0]));
    qz_d = 36'(snoise_pkg::floor_div3(sz[32:0]));
    h1_d = (seed_i + 32'h9E3779B9) ^ (cx_i * 32'h85EBCA6B);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qx_q <= qx_d; qy_q <= qy_d; qz_q <= qz_d;
      h1_q <= h1_d; cy1_q <= cy_i; cz1_q <= cz_i;
    end
  end

  // stage 2: squares, second hash mix
  logic [63:0] sqx_q, sqy_q, sqz_q;
  logic signed [35:0] qx2_q, qy2_q, qz2_q;
  logic [31:0] h2_q, cz2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= 64'(qx_q * qx_q);
      sqy_q <= 64'(qy_q * qy_q);
      sqz_q <= 64'(qz_q * qz_q);
      qx2_q <= qx_q; qy2_q <= qy_q; qz2_q <= qz_q;
      h2_q  <= snoise_pkg::xs(h1_q * 32'hC2B2AE35, 15) ^ (cy1_q * 32'h27D4EB2F);
      cz2_q <= cz1_q;
    end
  end

  // stage 3: r squared and falloff base, third hash mix
  logic signed [63:0] t_d, t_q;
  logic signed [35:0] qx3_q, qy3_q, qz3_q;
  logic [31:0] h3_q;
  always_comb begin
    logic [63:0] r2;
    r2  = (sqx_q + sqy_q + sqz_q) >> snoise_pkg::WorkBits;
    t_d = signed'(snoise_pkg::FalloffQ28 - r2);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_d;
      qx3_q <= qx2_q; qy3_q <= qy2_q; qz3_q <= qz2_q;
      h3_q <= snoise_pkg::xs(h2_q * 32'h165667B1, 13) ^ (cz2_q * 32'h9E3779B1);
    end
  end

  // stage 4: t squared, final hash, gradient dot
  logic signed [63:0] tt_q, dot_q;
  logic pos4_q;
  always_ff @(posedge clk_i) begin
    logic [31:0] h;
    snoise_pkg::grad_t g;
    if (en_i) begin
      h = snoise_pkg::xs(h3_q * 32'h85EBCA77, 16);
      g = snoise_pkg::grad_lookup(h[3:0]);
      pos4_q <= (t_q > 64'sd0);
      tt_q   <= (t_q[31:0] * t_q[31:0]) >>> snoise_pkg::WorkBits;
      dot_q  <= 64'(g.gx * qx3_q) + 64'(g.gy * qy3_q) + 64'(g.gz * qz3_q);
    end
  end

  // stage 5: t to the fourth
  logic signed [63:0] t4_q, dot5_q;
  logic pos5_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t4_q   <= (tt_q[31:0] * tt_q[31:0]) >>> snoise_pkg::WorkBits;
      dot5_q <= dot_q;
      pos5_q <= pos4_q;
    end
  end

  // stage 6: weighted contribution, both factors fit 32 signed bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_o <= pos5_q ? signed'(t4_q[31:0]) * signed'(dot5_q[31:0]) : 64'sd0;
    end
  end

  `ASSERT_NEXT(a_falloff_gate, clk_i, rst_ni, en_i && !pos4_q, !pos5_q, "falloff gate lost")

endmodule

`default_nettype wire

FILE: sv/simplex_noise_3d.sv
// 3d simplex noise sampler, one point per beat
// Channels: input beat pos_x/y/z (signed Q16.16) on in_valid_i/in_ready_o, result
// noise_value_o (signed Q2.16, saturated) on out_valid_o/out_ready_i, seed write
// beat on cfg_valid_i/cfg_ready_o (always ready).
// Stages from input beat to result valid: skew, cell and offsets, order, six
// corner stages, final sum. Throughput: one point per cycle while the receiver
// takes results; the pipeline is a chain of corner multipliers, no loop, so every
// stage takes a new point each cycle unless the pipeline holds.
// Reset clears the seed and all valid bits; payload registers are not reset.
// When the receiver stalls, the whole pipeline holds; in_ready_o follows the
// output register being empty or taken, so no beat is lost or repeated.
// Depends on snoise_pkg, snoise_corner and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module simplex_noise_3d #(
  parameter int unsigned FRAC_BITS = snoise_pkg::FracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [31:0]        noise_seed_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [17:0]      noise_value_o
);

  localparam int unsigned Lat = 10;
  localparam logic signed [39:0] Sixth = 40'sd1 <<< FRAC_BITS;
  localparam logic signed [39:0] Unit  = 40'sd6 <<< FRAC_BITS;

  logic [31:0] seed_q;
  logic [Lat-1:0] vld_q;
  logic en;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[Lat-1];

  // seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= '0;
    else if (cfg_valid_i) seed_q <= noise_seed_i;
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], in_valid_i};
  end

  // stage a: skewed sums
  logic signed [35:0] sx_q, sy_q, sz_q;
  logic signed [31:0] px_q, py_q, pz_q;
  always_ff @(posedge clk_i) begin
    logic signed [35:0] s;
    if (en) begin
      s = 36'(pos_x_i) + 36'(pos_y_i) + 36'(pos_z_i);
      sx_q <= 36'(pos_x_i) * 36'sd3 + s;
      sy_q <= 36'(pos_y_i) * 36'sd3 + s;
      sz_q <= 36'(pos_z_i) * 36'sd3 + s;
      px_q <= pos_x_i; py_q <= pos_y_i; pz_q <= pos_z_i;
    end
  end

  // stage b: cell index by floor division by 3*2^FRAC_BITS, offsets
  logic signed [35:0] ci_q, cj_q, ck_q;
  logic signed [39:0] x0_q, y0_q, z0_q;
  function automatic logic signed [35:0] fdiv3(input logic signed [35:0] v);
    logic signed [35:0] f;
    f = v >>> FRAC_BITS;
    return 36'(snoise_pkg::floor_div3(f[32:0]));
  endfunction
  always_ff @(posedge clk_i) begin
    logic signed [35:0] i, j, k;
    logic signed [39:0] back;
    if (en) begin
      i = fdiv3(sx_q); j = fdiv3(sy_q); k = fdiv3(sz_q);
      back = 40'(i + j + k) <<< FRAC_BITS;
      ci_q <= i; cj_q <= j; ck_q <= k;
      x0_q <= 40'(px_q) * 40'sd6 - 40'(i) * Unit + back;
      y0_q <= 40'(py_q) * 40'sd6 - 40'(j) * Unit + back;
      z0_q <= 40'(pz_q) * 40'sd6 - 40'(k) * Unit + back;
    end
  end

  // stage c: tetrahedron order and four corners
  logic signed [39:0] ex_q[4], ey_q[4], ez_q[4];
  logic [31:0] cx_q[4], cy_q[4], cz_q[4];
  always_ff @(posedge clk_i) begin
    logic a1, b1, c1, a2, b2, c2;
    logic [31:0] ui, uj, uk;
    if (en) begin
      if (x0_q >= y0_q) begin
        if (y0_q >= z0_q)      {a1,b1,c1,a2,b2,c2} = 6'b100110;
        else if (x0_q >= z0_q) {a1,b1,c1,a2,b2,c2} = 6'b100101;
        else                   {a1,b1,c1,a2,b2,c2} = 6'b001101;
      end else begin
        if (y0_q < z0_q)       {a1,b1,c1,a2,b2,c2} = 6'b001011;
        else if (x0_q < z0_q)  {a1,b1,c1,a2,b2,c2} = 6'b010011;
        else                   {a1,b1,c1,a2,b2,c2} = 6'b010110;
      end
      ui = ci_q[31:0]; uj = cj_q[31:0]; uk = ck_q[31:0];
      ex_q[0] <= x0_q; ey_q[0] <= y0_q; ez_q[0] <= z0_q;
      cx_q[0] <= ui; cy_q[0] <= uj; cz_q[0] <= uk;
      ex_q[1] <= x0_q - (a1 ? Unit : '0) + Sixth;
      ey_q[1] <= y0_q - (b1 ? Unit : '0) + Sixth;
      ez_q[1] <= z0_q - (c1 ? Unit : '0) + Sixth;
      cx_q[1] <= ui + 32'(a1); cy_q[1] <= uj + 32'(b1); cz_q[1] <= uk + 32'(c1);
      ex_q[2] <= x0_q - (a2 ? Unit : '0) + 2 * Sixth;
      ey_q[2] <= y0_q - (b2 ? Unit : '0) + 2 * Sixth;
      ez_q[2] <= z0_q - (c2 ? Unit : '0) + 2 * Sixth;
      cx_q[2] <= ui + 32'(a2); cy_q[2] <= uj + 32'(b2); cz_q[2] <= uk + 32'(c2);
      ex_q[3] <= x0_q - Unit + 3 * Sixth;
      ey_q[3] <= y0_q - Unit + 3 * Sixth;
      ez_q[3] <= z0_q - Unit + 3 * Sixth;
      cx_q[3] <= ui + 32'd1; cy_q[3] <= uj + 32'd1; cz_q[3] <= uk + 32'd1;
    end
  end

  // four corner lanes
  logic signed [63:0] term[4];
  for (genvar c = 0; c < 4; c++) begin : g_corner
    snoise_corner #(.FRAC_BITS(FRAC_BITS)) u_corner (
      .clk_i, .rst_ni, .en_i(en), .seed_i(seed_q),
      .ex_i(ex_q[c]), .ey_i(ey_q[c]), .ez_i(ez_q[c]),
      .cx_i(cx_q[c]), .cy_i(cy_q[c]), .cz_i(cz_q[c]),
      .term_o(term[c])
    );
  end

  // final sum, rounding and saturation
  always_ff @(posedge clk_i) begin
    logic signed [65:0] tot, v;
    if (en) begin
      tot = 66'(term[0]) + 66'(term[1]) + 66'(term[2]) + 66'(term[3]);
      v = (tot + (66'sd1 <<< 34)) >>> 35;
      if (v < -66'sd131072)     noise_value_o <= -18'sd131072;
      else if (v > 66'sd131071) noise_value_o <= 18'sd131071;
      else                      noise_value_o <= v[17:0];
    end
  end

  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `ASSERT_IMPL(a_ready, clk_i, rst_ni, !out_valid_o, in_ready_o, "stalled while empty")
  `ASSERT_NEXT(a_flow, clk_i, rst_ni, in_valid_i && in_ready_o, vld_q[0], "beat lost")

endmodule

`default_nettype wire

FILE: sim/simplex_noise_3d_tb.sv
// testbench for the 3d simplex noise sampler: directed table then random points
// depends on snoise_pkg and simplex_noise_3d
`timescale 1ns / 1ps

module simplex_noise_3d_tb;

  localparam int unsigned Frac = snoise_pkg::FracBits;
  localparam int LatencyCycles = 10;
  localparam longint CycleLimit = 400000;
  localparam int RandomCount = 800;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] noise_seed_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [17:0] noise_value_o;

  simplex_noise_3d DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .noise_seed_i(noise_seed_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .pos_x_i(pos_x_i), .pos_y_i(pos_y_i), .pos_z_i(pos_z_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .noise_value_o(noise_value_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [31:0] seed_model = '0;
  logic signed [17:0] noise_queue[$];
  int errors = 0;
  longint cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic logic [31:0] mix_corner(logic [31:0] cx, logic [31:0] cy,
                                             logic [31:0] cz, logic [31:0] seed);
    logic [31:0] h;
    h = seed + 32'h9E3779B9;
    h ^= cx * 32'h85EBCA6B;
    h *= 32'hC2B2AE35;
    h ^= h >> 15;
    h ^= cy * 32'h27D4EB2F;
    h *= 32'h165667B1;
    h ^= h >> 13;
    h ^= cz * 32'h9E3779B1;
    h *= 32'h85EBCA77;
    h ^= h >> 16;
    return h;
  endfunction

  // gradient component of edge vector g, axis a
  function automatic longint edge_grad(logic [3:0] g, int a);
    int tbl[16][3];
    tbl = '{'{1,1,0}, '{-1,1,0}, '{1,-1,0}, '{-1,-1,0},
            '{1,0,1}, '{-1,0,1}, '{1,0,-1}, '{-1,0,-1},
            '{0,1,1}, '{0,-1,1}, '{0,1,-1}, '{0,-1,-1},
            '{1,1,0}, '{0,-1,1}, '{-1,1,0}, '{0,-1,-1}};
    return tbl[g][a];
  endfunction

  // falloff-weighted dot product of one corner, Q56
  function automatic longint corner_weight(longint ex, longint ey, longint ez,
                                           logic [31:0] cx, logic [31:0] cy,
                                           logic [31:0] cz);
    longint qx, qy, qz, r2, t, dot;
    logic [31:0] h;
    logic [3:0] g;
    qx = fdiv(ex * (longint'(1) << (28 - Frac)), 6);
    qy = fdiv(ey * (longint'(1) << (28 - Frac)), 6);
    qz = fdiv(ez * (longint'(1) << (28 - Frac)), 6);
    r2 = (qx * qx + qy * qy + qz * qz) >>> 28;
    t = 161061274 - r2;
    if (t <= 0) return 0;
    t = (t * t) >>> 28;
    t = (t * t) >>> 28;
    h = mix_corner(cx, cy, cz, seed_model);
    g = h[3:0];
    dot = edge_grad(g, 0) * qx + edge_grad(g, 1) * qy + edge_grad(g, 2) * qz;
    return t * dot;
  endfunction

  function automatic logic signed [17:0] predict_noise(logic signed [31:0] px,
                                                       logic signed [31:0] py,
                                                       logic signed [31:0] pz);
    longint x, y, z, s, i, j, k, six, unit, back, x0, y0, z0, total, v;
    int a1, b1, c1, a2, b2, c2;
    logic [31:0] ui, uj, uk;
    x = px; y = py; z = pz;
    s = x + y + z;
    i = fdiv(3 * x + s, longint'(3) << Frac);
    j = fdiv(3 * y + s, longint'(3) << Frac);
    k = fdiv(3 * z + s, longint'(3) << Frac);
    six = longint'(1) << Frac;
    unit = 6 * six;
    back = (i + j + k) * six;
    x0 = 6 * x - i * unit + back;
    y0 = 6 * y - j * unit + back;
    z0 = 6 * z - k * unit + back;
    ui = i[31:0]; uj = j[31:0]; uk = k[31:0];
    // tetrahedron from the order of the offsets
    if (x0 >= y0) begin
      if (y0 >= z0) begin a1=1; b1=0; c1=0; a2=1; b2=1; c2=0; end
      else if (x0 >= z0) begin a1=1; b1=0; c1=0; a2=1; b2=0; c2=1; end
      else begin a1=0; b1=0; c1=1; a2=1; b2=0; c2=1; end
    end else begin
      if (y0 < z0) begin a1=0; b1=0; c1=1; a2=0; b2=1; c2=1; end
      else if (x0 < z0) begin a1=0; b1=1; c1=0; a2=0; b2=1; c2=1; end
      else begin a1=0; b1=1; c1=0; a2=1; b2=1; c2=0; end
    end
    total = corner_weight(x0, y0, z0, ui, uj, uk);
    total += corner_weight(x0 - a1 * unit + six, y0 - b1 * unit + six,
                           z0 - c1 * unit + six, ui + a1, uj + b1, uk + c1);
    total += corner_weight(x0 - a2 * unit + 2 * six, y0 - b2 * unit + 2 * six,
                           z0 - c2 * unit + 2 * six, ui + a2, uj + b2, uk + c2);
    total += corner_weight(x0 - unit + 3 * six, y0 - unit + 3 * six,
                           z0 - unit + 3 * six, ui + 1, uj + 1, uk + 1);
    v = (total + (longint'(1) << 34)) >>> 35;
    if (v < -131072) v = -131072;
    if (v > 131071) v = 131071;
    return v[17:0];
  endfunction

  // seed write while the pipeline is empty
  task automatic write_seed(logic [31:0] seed);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    noise_seed_i <= seed;
    do @(posedge clk_i); while (!cfg_ready_o);
    seed_model = seed;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one point beat; the expected value is queued at acceptance, either typed in
  // or from the predictor
  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz, bit use_val = 1'b0,
                            logic signed [17:0] val = '0);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    do @(posedge clk_i); while (!in_ready_o);
    if (use_val) noise_queue.push_back(val);
    else noise_queue.push_back(predict_noise(px, py, pz));
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (noise_queue.size() != 0) @(negedge clk_i);
    repeat (LatencyCycles + 4) @(negedge clk_i);
  endtask

  // receiver ready with random idling and one long hold-off
  always @(negedge clk_i) begin
    if (hold_recv) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result check against oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (noise_queue.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0d", $time, noise_value_o);
        errors++;
      end else begin
        logic signed [17:0] want;
        want = noise_queue.pop_front();
        if (noise_value_o !== want) begin
          $display("%0t noise mismatch: expected %0d, actual %0d", $time, want,
                   noise_value_o);
          errors++;
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  typedef struct {
    logic signed [31:0] x, y, z;
    bit fixed;
    logic signed [17:0] val;
  } point_row_t;

  point_row_t dir_rows[$];
  logic [31:0] seed_list[4] = '{32'h0, 32'hFFFFFFFF, 32'h12345678, 32'hA5A5A5A5};

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  initial begin
    int n, m;
    // origin: first corner has zero offset, the other three lie beyond the falloff
    dir_rows.push_back('{32'sd0, 32'sd0, 32'sd0, 1'b1, 18'sd0});
    dir_rows.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 18'sd0});
    dir_rows.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, 18'sd0});
    dir_rows.push_back('{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 1'b0, 18'sd0});
    dir_rows.push_back('{32'sh80000000, 32'sh7FFFFFFF, 32'shFFFFFFFF, 1'b0, 18'sd0});
    dir_rows.push_back('{32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, 1'b0, 18'sd0});
    // each tetrahedron order
    dir_rows.push_back('{32'sh0000C000, 32'sh00008000, 32'sh00004000, 1'b0, 18'sd0});
    dir_rows.push_back('{32'sh0000C000, 32'sh00004000, 32'sh00008000, 1'b0, 18'sd0});
    dir_rows.push_back('{32'sh00008000, 32'sh00004000, 32'sh0000C000, 1'b0, 18'sd0});
    dir_rows.push_back('{32'sh00004000, 32'sh00008000, 32'sh0000C000, 1'b0, 18'sd0});
    dir_rows.push_back('{32'sh00004000, 32'sh0000C000, 32'sh00008000, 1'b0, 18'sd0});
    dir_rows.push_back('{32'sh00008000, 32'sh0000C000, 32'sh00004000, 1'b0, 18'sd0});
    // near lattice points and cell edges, falloff cut
    dir_rows.push_back('{32'sh00010000, 32'sh00000000, 32'sh00000000, 1'b0, 18'sd0});
    dir_rows.push_back('{32'sh00005555, 32'sh00005555, 32'sh00005555, 1'b0, 18'sd0});
    dir_rows.push_back('{32'shFFFF0000, 32'sh00010000, 32'shFFFF8000, 1'b0, 18'sd0});
    dir_rows.push_back('{32'sh00001234, 32'shFFFFEDCB, 32'sh00002000, 1'b0, 18'sd0});
    dir_rows.push_back('{32'sh55555555, 32'shAAAAAAAA, 32'sh33333333, 1'b0, 18'sd0});

    #1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table with reset seed
    foreach (dir_rows[r]) begin
      send_point(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z, dir_rows[r].fixed,
                 dir_rows[r].val);
    end
    drain();

    // random phases over seeds and idling mixes
    for (n = 0; n < 4; n++) begin
      write_seed((n == 3) ? $urandom() : seed_list[n + 1]);
      case (n)
        0: begin send_idle_pct = 12; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (m = 0; m < RandomCount / 4; m++) begin
        if (n == 2 && m == 20) hold_recv = 1'b1;
        if (n == 2 && m == 20) begin
          fork
            begin
              repeat (60) @(posedge clk_i);
              hold_recv = 1'b0;
            end
          join_none
        end
        send_point(rand_coord(m % 3), rand_coord($urandom_range(2)),
                   rand_coord($urandom_range(2)));
      end
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/snoise_pkg.sv
sv/snoise_corner.sv
sv/simplex_noise_3d.sv
sim/simplex_noise_3d_tb.sv
